/* design/png_rgb_stored_deflate_encoder_assert.svh */
// assertion macros shared by the checker of the png encoder
// no dependencies; take in with `include before use
`ifndef PNG_RGB_STORED_DEFLATE_ENCODER_ASSERT_SVH
`define PNG_RGB_STORED_DEFLATE_ENCODER_ASSERT_SVH

// implication checked in the next cycle, off during reset
`define PNGENC_AST_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("pngenc assertion failed");

// what must hold in the cycle after a reset cycle
`define PNGENC_AST_RST(lbl, ck, rn, cons) \
  lbl: assert property (@(posedge ck) !(rn) |=> (cons)) \
    else $error("pngenc reset assertion failed");

`endif

/* design/pngenc_pkg.sv */
// types, constants and byte helpers of the png encoder
// no dependencies; used by every module of the block but the pixel queue
package pngenc_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       file_last;
  } res_t;

  // classification of one pixel by the front end
  typedef struct packed {
    logic start;
    logic filter;
    logic finish;
  } cls_t;

  // one entry of the byte buffer
  typedef struct packed {
    logic [7:0] data;
    logic       file_end;
  } qent_t;

  typedef enum logic [4:0] {
    G_IDLE, G_MUL, G_DIVLD, G_SIG, G_IHLEN, G_IHDR, G_IHCRC, G_ZWAIT, G_ZLEN,
    G_IDAT, G_RAW, G_BLK, G_ADLER, G_ICRC, G_ELEN, G_IEND, G_ECRC
  } gen_state_t;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam int unsigned BUF_DEPTH = 512;
  localparam int unsigned BUF_AW    = 9;
  localparam int unsigned RELQ_AW   = 2;
  localparam logic [RELQ_AW:0] RELQ_DEPTH = 3'd4;
  localparam logic [8:0] HOLD_CAP  = 9'd256;
  localparam logic [8:0] BURST_MAX = 9'd64;

  // largest stored block; the block count fold relies on it being 2^16-1
  localparam logic [16:0] MAX_BLOCK_BYTES = 17'd65535;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam logic [31:0] TAG_IHDR = 32'h49484452;
  localparam logic [31:0] TAG_IDAT = 32'h49444154;
  localparam logic [31:0] TAG_IEND = 32'h49454E44;
  localparam logic [31:0] IHDR_LEN = 32'd13;
  localparam logic [7:0]  BIT_DEPTH   = 8'd8;
  localparam logic [7:0]  COLOUR_TYPE = 8'd2;
  localparam logic [7:0]  ZLIB_CMF    = 8'h78;
  localparam logic [7:0]  ZLIB_FLG    = 8'h01;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) x = (x >> 1) ^ (x[0] ? CRC_POLY : 32'h0);
    return x;
  endfunction

  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] i);
    logic [7:0] b;
    unique case (i)
      2'd0: b = v[31:24];
      2'd1: b = v[23:16];
      2'd2: b = v[15:8];
      default: b = v[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0: b = 8'd137;
      3'd1: b = 8'd80;
      3'd2: b = 8'd78;
      3'd3: b = 8'd71;
      3'd4: b = 8'd13;
      3'd5: b = 8'd10;
      3'd6: b = 8'd26;
      default: b = 8'd10;
    endcase
    return b;
  endfunction

endpackage

/* design/pngenc_front.sv */
// front end: configuration registers, pixel intake and row/image position
// depends on pngenc_pkg
module pngenc_front #(
  parameter int DIM_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_idx,
  input  logic [DIM_BITS-1:0]     cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  pngenc_pkg::pix_t        in_data,
  input  logic                    q_full,
  output logic                    q_push,
  output pngenc_pkg::cls_t        cmd_cls,
  output pngenc_pkg::pix_t        cmd_pix,
  output logic [DIM_BITS-1:0]     cmd_width,
  output logic [DIM_BITS-1:0]     cmd_height
);

  logic [DIM_BITS-1:0] cfg_w_r, cfg_h_r, held_w_r, held_h_r, col_r, row_r;
  logic                sent_r;
  logic                start, row_end, finish;
  logic [DIM_BITS-1:0] eff_w, eff_h, col_cur, row_cur;
  logic [DIM_BITS:0]   col_inc, row_inc;

  always_comb begin
    start   = !sent_r;
    eff_w   = start ? ((cfg_w_r == '0) ? DIM_BITS'(1) : cfg_w_r) : held_w_r;
    eff_h   = start ? ((cfg_h_r == '0) ? DIM_BITS'(1) : cfg_h_r) : held_h_r;
    col_cur = start ? '0 : col_r;
    row_cur = start ? '0 : row_r;
    col_inc = {1'b0, col_cur} + (DIM_BITS+1)'(1);
    row_inc = {1'b0, row_cur} + (DIM_BITS+1)'(1);
    row_end = col_inc >= {1'b0, eff_w};
    finish  = row_end && (row_inc >= {1'b0, eff_h});
  end

  assign in_stall       = q_full;
  assign q_push         = in_valid && !q_full;
  assign cmd_cls.start  = start;
  assign cmd_cls.filter = (col_cur == '0);
  assign cmd_cls.finish = finish;
  assign cmd_pix        = in_data;
  assign cmd_width      = eff_w;
  assign cmd_height     = eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= DIM_BITS'(1);
      cfg_h_r <= DIM_BITS'(1);
      sent_r  <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          pngenc_pkg::CFG_IDX_WIDTH:  cfg_w_r <= cfg_wdata;
          default:                    cfg_h_r <= cfg_wdata;
        endcase
      end
      if (q_push) begin
        col_r  <= row_end ? '0 : col_inc[DIM_BITS-1:0];
        row_r  <= row_end ? row_inc[DIM_BITS-1:0] : row_cur;
        sent_r <= !finish;
      end
    end
  end

  // latched image size, only read after the first pixel of an image has been taken
  always_ff @(posedge clk) begin
    if (q_push) begin
      held_w_r <= eff_w;
      held_h_r <= eff_h;
    end
  end

endmodule

/* design/pngenc_cmdq.sv */
// two-entry queue of classified pixels between front end and byte generator
// depends on nothing but its parameter
module pngenc_cmdq #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  input  logic              pop,
  output logic [DATA_W-1:0] dout,
  output logic              full,
  output logic              avail
);

  logic [DATA_W-1:0] slot_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign dout  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= din;
  end

endmodule

/* design/pngenc_gen.sv */
// byte generator: walks header, stored blocks, checksums and trailer per pixel
// depends on pngenc_pkg
module pngenc_gen #(
  parameter int DIM_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_avail,
  input  pngenc_pkg::cls_t      cmd_cls,
  input  pngenc_pkg::pix_t      cmd_pix,
  input  logic [DIM_BITS-1:0]   cmd_width,
  input  logic [DIM_BITS-1:0]   cmd_height,
  output logic                  cmd_pop,
  input  logic                  buf_full,
  output logic                  wr_en,
  output pngenc_pkg::qent_t     wr_ent,
  input  logic                  relq_full,
  output logic                  rel_push,
  output logic [6:0]            rel_cnt
);

  localparam int RAW_W = 2*DIM_BITS + 2;
  localparam int CMP_W = (RAW_W > 17) ? RAW_W : 17;
  localparam int DIV_W = CMP_W + 1;
  localparam int ZW    = (DIV_W + 4 > 32) ? DIV_W + 4 : 32;
  localparam logic [15:0]      MAX16 = 16'(pngenc_pkg::MAX_BLOCK_BYTES);
  localparam logic [CMP_W-1:0] MAXC  = CMP_W'(pngenc_pkg::MAX_BLOCK_BYTES);
  localparam logic [DIV_W-1:0] MAXM1 = DIV_W'(pngenc_pkg::MAX_BLOCK_BYTES - 17'd1);

  pngenc_pkg::gen_state_t state_r, state_nxt;
  logic [4:0]          idx_r, idx_nxt;
  logic [1:0]          sel_r, sel_nxt;
  pngenc_pkg::cls_t    cls_r, cls_nxt;
  pngenc_pkg::pix_t    pix_r, pix_nxt;
  logic [DIM_BITS-1:0] w_r, w_nxt, h_r, h_nxt;
  logic [RAW_W-1:0]    raw_left_r, raw_left_nxt;
  logic [31:0]         zlen_r, zlen_nxt;
  logic [15:0]         blk_left_r, blk_left_nxt, blk_len_r, blk_len_nxt;
  logic                bfinal_r, bfinal_nxt;
  logic [15:0]         low_r, low_nxt, high_r, high_nxt;
  logic [31:0]         chunk_r, chunk_nxt, aux_r, aux_nxt;
  logic [8:0]          mcount_r, mcount_nxt;

  logic [DIV_W-1:0]    fold_v_r, fold_q_r, fold_hi, blocks;
  logic                fold_done;

  logic                emit_v, emit_end, emit_chk, emit_aux, step_end, dispatch, keep, go;
  logic [7:0]          emit_b, raw_b;
  logic [8:0]          mc_after, burst;
  logic [31:0]         w32, h32;
  logic [DIM_BITS+1:0] w3;
  logic [16:0]         low_sum, low_red, high_sum;
  logic [ZW-1:0]       zsum;
  logic                raw_lt_max;

  always_comb begin
    w32 = 32'(w_r);
    h32 = 32'(h_r);
    w3  = {1'b0, w_r, 1'b0} + {2'b00, w_r} + (DIM_BITS+2)'(1);
    fold_hi   = fold_v_r >> 16;
    fold_done = (fold_hi == '0);
    blocks    = fold_q_r + DIV_W'(fold_v_r[15:0] == 16'hFFFF);
    zsum = (ZW'(blocks) << 2) + ZW'(blocks) + ZW'(raw_left_r) + ZW'(6);
    raw_lt_max = CMP_W'(raw_left_r) < MAXC;
    unique case (sel_r)
      2'd0: raw_b = 8'd0;
      2'd1: raw_b = pix_r.red;
      2'd2: raw_b = pix_r.green;
      default: raw_b = pix_r.blue;
    endcase
    // adler-32 step, both sums kept below the modulus
    low_sum  = {1'b0, low_r} + {9'd0, raw_b};
    low_red  = (low_sum >= pngenc_pkg::ADLER_MOD) ? low_sum - pngenc_pkg::ADLER_MOD : low_sum;
    high_sum = {1'b0, high_r} + low_red;
  end

  always_comb begin
    state_nxt = state_r;  idx_nxt = idx_r;  sel_nxt = sel_r;
    cls_nxt = cls_r;  pix_nxt = pix_r;  w_nxt = w_r;  h_nxt = h_r;
    raw_left_nxt = raw_left_r;  zlen_nxt = zlen_r;
    blk_left_nxt = blk_left_r;  blk_len_nxt = blk_len_r;  bfinal_nxt = bfinal_r;
    low_nxt = low_r;  high_nxt = high_r;  chunk_nxt = chunk_r;  aux_nxt = aux_r;
    emit_v = 1'b0;  emit_b = 8'd0;  emit_end = 1'b0;  emit_chk = 1'b0;  emit_aux = 1'b0;
    step_end = 1'b0;  dispatch = 1'b0;

    unique case (state_r)
      pngenc_pkg::G_IDLE: dispatch = 1'b1;
      pngenc_pkg::G_MUL: begin
        raw_left_nxt = h_r * w3;
        low_nxt      = 16'd1;
        high_nxt     = 16'd0;
        blk_left_nxt = 16'd0;
        sel_nxt      = 2'd0;
        state_nxt    = pngenc_pkg::G_DIVLD;
      end
      pngenc_pkg::G_DIVLD: begin
        idx_nxt   = 5'd0;
        state_nxt = pngenc_pkg::G_SIG;
      end
      pngenc_pkg::G_SIG: begin
        emit_v = 1'b1;
        emit_b = pngenc_pkg::sig_byte(idx_r[2:0]);
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'd7) begin
          idx_nxt   = 5'd0;
          state_nxt = pngenc_pkg::G_IHLEN;
        end
      end
      pngenc_pkg::G_IHLEN: begin
        emit_v = 1'b1;
        emit_b = pngenc_pkg::be_byte(pngenc_pkg::IHDR_LEN, idx_r[1:0]);
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'd3) begin
          idx_nxt   = 5'd0;
          aux_nxt   = pngenc_pkg::CRC_INIT;
          state_nxt = pngenc_pkg::G_IHDR;
        end
      end
      pngenc_pkg::G_IHDR: begin
        emit_v   = 1'b1;
        emit_aux = 1'b1;
        if (idx_r < 5'd4)       emit_b = pngenc_pkg::be_byte(pngenc_pkg::TAG_IHDR, idx_r[1:0]);
        else if (idx_r < 5'd8)  emit_b = pngenc_pkg::be_byte(w32, idx_r[1:0]);
        else if (idx_r < 5'd12) emit_b = pngenc_pkg::be_byte(h32, idx_r[1:0]);
        else if (idx_r == 5'd12) emit_b = pngenc_pkg::BIT_DEPTH;
        else if (idx_r == 5'd13) emit_b = pngenc_pkg::COLOUR_TYPE;
        else                     emit_b = 8'd0;
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'd16) begin
          idx_nxt   = 5'd0;
          state_nxt = pngenc_pkg::G_IHCRC;
        end
      end
      pngenc_pkg::G_IHCRC: begin
        emit_v = 1'b1;
        emit_b = pngenc_pkg::be_byte(~aux_r, idx_r[1:0]);
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'd3) begin
          idx_nxt   = 5'd0;
          state_nxt = pngenc_pkg::G_ZWAIT;
        end
      end
      pngenc_pkg::G_ZWAIT: begin
        // block count comes from the fold below
        if (fold_done) begin
          zlen_nxt  = zsum[31:0];
          state_nxt = pngenc_pkg::G_ZLEN;
        end
      end
      pngenc_pkg::G_ZLEN: begin
        emit_v = 1'b1;
        emit_b = pngenc_pkg::be_byte(zlen_r, idx_r[1:0]);
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'd3) begin
          idx_nxt   = 5'd0;
          chunk_nxt = pngenc_pkg::CRC_INIT;
          state_nxt = pngenc_pkg::G_IDAT;
        end
      end
      pngenc_pkg::G_IDAT: begin
        emit_v   = 1'b1;
        emit_chk = 1'b1;
        if (idx_r < 5'd4)       emit_b = pngenc_pkg::be_byte(pngenc_pkg::TAG_IDAT, idx_r[1:0]);
        else if (idx_r == 5'd4) emit_b = pngenc_pkg::ZLIB_CMF;
        else                    emit_b = pngenc_pkg::ZLIB_FLG;
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'd5) begin
          idx_nxt   = 5'd0;
          state_nxt = pngenc_pkg::G_RAW;
        end
      end
      pngenc_pkg::G_RAW: begin
        if (raw_left_r != '0 && blk_left_r == 16'd0) begin
          // open a new stored block
          blk_len_nxt = raw_lt_max ? 16'(raw_left_r) : MAX16;
          bfinal_nxt  = CMP_W'(raw_left_r) <= MAXC;
          idx_nxt     = 5'd0;
          state_nxt   = pngenc_pkg::G_BLK;
        end else begin
          if (raw_left_r != '0) begin
            emit_v       = 1'b1;
            emit_chk     = 1'b1;
            emit_b       = raw_b;
            blk_left_nxt = blk_left_r - 16'd1;
            raw_left_nxt = raw_left_r - RAW_W'(1);
            low_nxt      = low_red[15:0];
            high_nxt     = (high_sum >= pngenc_pkg::ADLER_MOD) ?
                           16'(high_sum - pngenc_pkg::ADLER_MOD) : high_sum[15:0];
          end
          sel_nxt = sel_r + 2'd1;
          if (sel_r == 2'd3) begin
            if (cls_r.finish) begin
              idx_nxt   = 5'd0;
              state_nxt = pngenc_pkg::G_ADLER;
            end else begin
              step_end = 1'b1;
            end
          end
        end
      end
      pngenc_pkg::G_BLK: begin
        emit_v   = 1'b1;
        emit_chk = 1'b1;
        case (idx_r)
          5'd0:    emit_b = {7'd0, bfinal_r};
          5'd1:    emit_b = blk_len_r[7:0];
          5'd2:    emit_b = blk_len_r[15:8];
          5'd3:    emit_b = ~blk_len_r[7:0];
          default: emit_b = ~blk_len_r[15:8];
        endcase
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'd4) begin
          idx_nxt      = 5'd0;
          blk_left_nxt = blk_len_r;
          state_nxt    = pngenc_pkg::G_RAW;
        end
      end
      pngenc_pkg::G_ADLER: begin
        emit_v   = 1'b1;
        emit_chk = 1'b1;
        emit_b   = pngenc_pkg::be_byte({high_r, low_r}, idx_r[1:0]);
        idx_nxt  = idx_r + 5'd1;
        if (idx_r == 5'd3) begin
          idx_nxt   = 5'd0;
          state_nxt = pngenc_pkg::G_ICRC;
        end
      end
      pngenc_pkg::G_ICRC: begin
        emit_v  = 1'b1;
        emit_b  = pngenc_pkg::be_byte(~chunk_r, idx_r[1:0]);
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'd3) begin
          idx_nxt   = 5'd0;
          state_nxt = pngenc_pkg::G_ELEN;
        end
      end
      pngenc_pkg::G_ELEN: begin
        emit_v  = 1'b1;
        emit_b  = 8'd0;
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'd3) begin
          idx_nxt   = 5'd0;
          aux_nxt   = pngenc_pkg::CRC_INIT;
          state_nxt = pngenc_pkg::G_IEND;
        end
      end
      pngenc_pkg::G_IEND: begin
        emit_v   = 1'b1;
        emit_aux = 1'b1;
        emit_b   = pngenc_pkg::be_byte(pngenc_pkg::TAG_IEND, idx_r[1:0]);
        idx_nxt  = idx_r + 5'd1;
        if (idx_r == 5'd3) begin
          idx_nxt   = 5'd0;
          state_nxt = pngenc_pkg::G_ECRC;
        end
      end
      pngenc_pkg::G_ECRC: begin
        emit_v  = 1'b1;
        emit_b  = pngenc_pkg::be_byte(~aux_r, idx_r[1:0]);
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'd3) begin
          idx_nxt  = 5'd0;
          emit_end = 1'b1;
          step_end = 1'b1;
        end
      end
      default: state_nxt = pngenc_pkg::G_IDLE;
    endcase

    if (emit_v && emit_chk) chunk_nxt = pngenc_pkg::crc_byte(chunk_r, emit_b);
    if (emit_v && emit_aux) aux_nxt   = pngenc_pkg::crc_byte(aux_r, emit_b);

    // next pixel, if one is waiting, is taken in the same cycle as the last byte of this one
    if (step_end) begin
      dispatch  = 1'b1;
      state_nxt = pngenc_pkg::G_IDLE;
    end
    if (dispatch && cmd_avail) begin
      cls_nxt   = cmd_cls;
      pix_nxt   = cmd_pix;
      w_nxt     = cmd_width;
      h_nxt     = cmd_height;
      sel_nxt   = cmd_cls.filter ? 2'd0 : 2'd1;
      state_nxt = cmd_cls.start ? pngenc_pkg::G_MUL : pngenc_pkg::G_RAW;
    end
  end

  // bytes past the hold limit are counted out, not stored
  always_comb begin
    keep     = (mcount_r != pngenc_pkg::HOLD_CAP);
    go       = !(emit_v && keep && buf_full) && !(step_end && relq_full);
    mc_after = mcount_r + {8'd0, emit_v && keep};
    burst    = (mc_after > pngenc_pkg::BURST_MAX) ? pngenc_pkg::BURST_MAX : mc_after;
    mcount_nxt = step_end ? mc_after - burst : mc_after;
  end

  assign wr_en           = emit_v && keep && go;
  assign wr_ent.data     = emit_b;
  assign wr_ent.file_end = emit_end;
  assign rel_push        = step_end && go;
  assign rel_cnt         = burst[6:0];
  assign cmd_pop         = dispatch && cmd_avail && go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pngenc_pkg::G_IDLE;
      mcount_r <= 9'd0;
    end else if (go) begin
      state_r  <= state_nxt;
      mcount_r <= mcount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      idx_r <= idx_nxt;  sel_r <= sel_nxt;  cls_r <= cls_nxt;  pix_r <= pix_nxt;
      w_r <= w_nxt;  h_r <= h_nxt;  raw_left_r <= raw_left_nxt;  zlen_r <= zlen_nxt;
      blk_left_r <= blk_left_nxt;  blk_len_r <= blk_len_nxt;  bfinal_r <= bfinal_nxt;
      low_r <= low_nxt;  high_r <= high_nxt;  chunk_r <= chunk_nxt;  aux_r <= aux_nxt;
    end
  end

  // blocks = ceil(raw / 65535): 65536 leaves 1 mod 65535, so folding the high part
  // onto the low part keeps the remainder while the high parts sum to the quotient;
  // three folds at most, done long before the header reaches the idat length
  always_ff @(posedge clk) begin
    if (state_r == pngenc_pkg::G_DIVLD) begin
      fold_v_r <= DIV_W'(raw_left_r) + MAXM1;
      fold_q_r <= '0;
    end else if (!fold_done) begin
      fold_q_r <= fold_q_r + fold_hi;
      fold_v_r <= fold_hi + DIV_W'(fold_v_r[15:0]);
    end
  end

endmodule

/* design/pngenc_outq.sv */
// byte buffer and release queue feeding the registered result port
// depends on pngenc_pkg
module pngenc_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  pngenc_pkg::qent_t  wr_ent,
  output logic               buf_full,
  input  logic               rel_push,
  input  logic [6:0]         rel_cnt,
  output logic               relq_full,
  output logic               out_valid,
  input  logic               out_stall,
  output pngenc_pkg::res_t   out_data
);

  localparam int AW = pngenc_pkg::BUF_AW;
  localparam int QW = pngenc_pkg::RELQ_AW;

  pngenc_pkg::qent_t mem [pngenc_pkg::BUF_DEPTH];
  pngenc_pkg::qent_t mem_q_r;
  logic [AW:0]       wptr_r, rptr_r;
  logic [6:0]        relq_r [2**QW];
  logic [QW:0]       rq_w_r, rq_r_r;
  logic [6:0]        rel_left_r, cur_left;
  logic              rd_pend_r, rd_last_r, out_valid_r;
  pngenc_pkg::res_t  out_data_r;
  logic              rq_empty, avail, move, issue;

  always_comb begin
    buf_full  = (wptr_r[AW] != rptr_r[AW]) && (wptr_r[AW-1:0] == rptr_r[AW-1:0]);
    relq_full = (rq_w_r - rq_r_r) == pngenc_pkg::RELQ_DEPTH;
    rq_empty  = (rq_w_r == rq_r_r);
    cur_left  = (rel_left_r != 7'd0) ? rel_left_r : relq_r[rq_r_r[QW-1:0]];
    avail     = (rel_left_r != 7'd0) || !rq_empty;
    move      = rd_pend_r && (!out_valid_r || !out_stall);
    issue     = avail && (!rd_pend_r || move);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wptr_r[AW-1:0]] <= wr_ent;
    if (issue) mem_q_r <= mem[rptr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rel_push) relq_r[rq_w_r[QW-1:0]] <= rel_cnt;
    if (issue) rd_last_r <= (cur_left == 7'd1);
    if (move) begin
      out_data_r.out_byte  <= mem_q_r.data;
      out_data_r.run_last  <= rd_last_r;
      out_data_r.file_last <= mem_q_r.file_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r      <= '0;
      rptr_r      <= '0;
      rq_w_r      <= '0;
      rq_r_r      <= '0;
      rel_left_r  <= 7'd0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en)    wptr_r <= wptr_r + (AW+1)'(1);
      if (rel_push) rq_w_r <= rq_w_r + (QW+1)'(1);
      if (issue) begin
        rptr_r     <= rptr_r + (AW+1)'(1);
        rel_left_r <= cur_left - 7'd1;
        if (rel_left_r == 7'd0) rq_r_r <= rq_r_r + (QW+1)'(1);
      end
      rd_pend_r <= issue || (rd_pend_r && !move);
      if (move)            out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

endmodule

/* design/png_rgb_stored_deflate_encoder.sv */
// Streams an 8-bit RGB PNG file from pixels in raster order, image data in stored
// deflate blocks of up to 65535 bytes. Bytes leave one per cycle at most; the byte
// generator emits a pixel's colour bytes, after a filter byte at the start of a row
// and after a stored block header wherever a block opens. A file's first pixel first
// emits the signature, IHDR, IDAT length and zlib header, the block count for the
// IDAT length coming from a short fold that finishes meanwhile; the last pixel adds
// the trailer. A pixel's bytes are released to the output port only once all of
// them are generated; the port then delivers at most 64 of them per pixel, later
// ones queued for the next pixel.
// Depends on pngenc_pkg and the front, queue, generator and buffer modules.
module png_rgb_stored_deflate_encoder #(
  parameter int DIM_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_idx,
  input  logic [DIM_BITS-1:0]   cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pngenc_pkg::pix_t      in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pngenc_pkg::res_t      out_data
);

  localparam int CMD_W = $bits(pngenc_pkg::cls_t) + $bits(pngenc_pkg::pix_t) + 2*DIM_BITS;

  pngenc_pkg::cls_t    f_cls, g_cls;
  pngenc_pkg::pix_t    f_pix, g_pix;
  logic [DIM_BITS-1:0] f_w, f_h, g_w, g_h;
  logic [CMD_W-1:0]    q_dout;
  logic                q_full, q_push, q_pop, q_avail;
  logic                buf_full, wr_en, relq_full, rel_push;
  pngenc_pkg::qent_t   wr_ent;
  logic [6:0]          rel_cnt;

  pngenc_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata, .in_valid, .in_stall, .in_data,
    .q_full, .q_push, .cmd_cls(f_cls), .cmd_pix(f_pix), .cmd_width(f_w), .cmd_height(f_h)
  );

  pngenc_cmdq #(.DATA_W(CMD_W)) u_cmdq (
    .clk, .rst_n, .push(q_push), .din({f_cls, f_pix, f_w, f_h}), .pop(q_pop),
    .dout(q_dout), .full(q_full), .avail(q_avail)
  );

  assign {g_cls, g_pix, g_w, g_h} = q_dout;

  pngenc_gen #(.DIM_BITS(DIM_BITS)) u_gen (
    .clk, .rst_n, .cmd_avail(q_avail), .cmd_cls(g_cls), .cmd_pix(g_pix),
    .cmd_width(g_w), .cmd_height(g_h), .cmd_pop(q_pop), .buf_full, .wr_en, .wr_ent,
    .relq_full, .rel_push, .rel_cnt
  );

  pngenc_outq u_outq (
    .clk, .rst_n, .wr_en, .wr_ent, .buf_full, .rel_push, .rel_cnt, .relq_full,
    .out_valid, .out_stall, .out_data
  );

endmodule

/* design/pngenc_checker.sv */
// port-level checks of the png encoder's result channel, bound to the top level
// depends on pngenc_pkg and png_rgb_stored_deflate_encoder_assert.svh
`include "png_rgb_stored_deflate_encoder_assert.svh"

module pngenc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input pngenc_pkg::res_t  out_data
);

  `PNGENC_AST_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `PNGENC_AST_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))
  // no second file end directly follows an accepted file end
  `PNGENC_AST_NEXT(a_file_gap, clk, rst_n, out_valid && !out_stall && out_data.file_last, !(out_valid && out_data.file_last))
  `PNGENC_AST_RST(a_rst_quiet, clk, rst_n, !out_valid)

endmodule

bind png_rgb_stored_deflate_encoder pngenc_checker u_pngenc_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);

/* bench/tb_png_rgb_stored_deflate_encoder.sv */
// testbench of the png rgb encoder: pixels in, png file bytes checked one by one
// holds its own byte-exact model of the file stream; depends on pngenc_pkg and the rtl
module tb_png_rgb_stored_deflate_encoder;

  localparam int BLK_MAX   = 65535;
  localparam int BURST     = 64;
  localparam int HOLD_MAX  = 256;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
  } fbyte_t;

  logic clk, rst_n;
  logic cfg_we, cfg_idx;
  logic [15:0] cfg_wdata;
  logic in_valid, in_stall, out_valid, out_stall;
  pngenc_pkg::pix_t in_data;
  pngenc_pkg::res_t out_data;

  png_rgb_stored_deflate_encoder DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // encoder model state
  logic [15:0] reg_w, reg_h;
  int unsigned img_w, img_h, col, row, blk_left;
  longint unsigned raw_left;
  int unsigned ad_lo, ad_hi;
  logic [31:0] idat_crc;
  bit in_file;
  fbyte_t pend_q[$];
  pngenc_pkg::res_t file_bytes_q[$];

  int errors;
  int idle_pct, stall_pct, hold_left;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    #100_000_000;
    $display("tb_png_rgb_stored_deflate_encoder: FAIL");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [31:0] crc_upd(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
    return r;
  endfunction

  function automatic void put(input logic [7:0] b, input logic e = 1'b0);
    if (pend_q.size() < HOLD_MAX) pend_q.push_back('{b: b, e: e});
  endfunction

  function automatic void put_idat(input logic [7:0] b);
    idat_crc = crc_upd(idat_crc, b);
    put(b);
  endfunction

  function automatic void put_word(input logic [31:0] v, input bit in_idat);
    for (int s = 3; s >= 0; s--) begin
      if (in_idat) put_idat(v[8*s +: 8]);
      else put(v[8*s +: 8]);
    end
  endfunction

  function automatic void put_raw(input logic [7:0] b);
    int unsigned len;
    if (raw_left == 0) return;
    if (blk_left == 0) begin
      len = (raw_left < BLK_MAX) ? int'(raw_left) : BLK_MAX;
      put_idat((raw_left <= BLK_MAX) ? 8'h01 : 8'h00);
      put_idat(len[7:0]);
      put_idat(len[15:8]);
      put_idat(~len[7:0]);
      put_idat(~len[15:8]);
      blk_left = len;
    end
    put_idat(b);
    blk_left--;
    raw_left--;
    ad_lo += b;
    if (ad_lo >= 65521) ad_lo -= 65521;
    ad_hi += ad_lo;
    if (ad_hi >= 65521) ad_hi -= 65521;
  endfunction

  function automatic void open_file();
    logic [7:0] ihdr [17];
    logic [31:0] c;
    longint unsigned nblk, zlen;
    logic [7:0] sig [8] = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};
    img_w = (reg_w == 0) ? 1 : reg_w;
    img_h = (reg_h == 0) ? 1 : reg_h;
    raw_left = longint'(img_h) * (1 + 3 * longint'(img_w));
    nblk = (raw_left + BLK_MAX - 1) / BLK_MAX;
    zlen = 2 + 5 * nblk + raw_left + 4;
    foreach (sig[i]) put(sig[i]);
    ihdr = '{"I", "H", "D", "R", 8'd0, 8'd0, img_w[15:8], img_w[7:0],
             8'd0, 8'd0, img_h[15:8], img_h[7:0], 8'd8, 8'd2, 8'd0, 8'd0, 8'd0};
    put_word(32'd13, 0);
    c = 32'hFFFFFFFF;
    foreach (ihdr[i]) begin
      put(ihdr[i]);
      c = crc_upd(c, ihdr[i]);
    end
    put_word(~c, 0);
    put_word(zlen[31:0], 0);
    idat_crc = 32'hFFFFFFFF;
    put_word(32'h49444154, 1);
    put_idat(8'h78);
    put_idat(8'h01);
    col = 0; row = 0; blk_left = 0; ad_lo = 1; ad_hi = 0;
    in_file = 1;
  endfunction

  function automatic void close_file();
    logic [31:0] c;
    put_word({ad_hi[15:0], ad_lo[15:0]}, 1);
    put_word(~idat_crc, 0);
    put_word(32'd0, 0);
    c = 32'hFFFFFFFF;
    for (int s = 3; s >= 0; s--) begin
      put(pngenc_pkg::TAG_IEND[8*s +: 8]);
      c = crc_upd(c, pngenc_pkg::TAG_IEND[8*s +: 8]);
    end
    c = ~c;
    put(c[31:24]); put(c[23:16]); put(c[15:8]);
    put(c[7:0], 1'b1);
    in_file = 0;
    idat_crc = 32'hFFFFFFFF;
  endfunction

  // bytes that one accepted pixel releases
  function automatic void encode_pixel(input pngenc_pkg::pix_t p);
    int n;
    fbyte_t f;
    if (!in_file) open_file();
    if (col == 0) put_raw(8'h00);
    put_raw(p.red);
    put_raw(p.green);
    put_raw(p.blue);
    col++;
    if (col >= img_w) begin
      col = 0;
      row++;
      if (row >= img_h) close_file();
    end
    n = (pend_q.size() < BURST) ? pend_q.size() : BURST;
    for (int i = 0; i < n; i++) begin
      f = pend_q.pop_front();
      file_bytes_q.push_back('{out_byte: f.b, run_last: (i == n - 1), file_last: f.e});
    end
  endfunction

  task automatic send_pixel(input pngenc_pkg::pix_t p);
    while ($urandom_range(99) < idle_pct) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    encode_pixel(p);
  endtask

  task automatic send_rand(input int n);
    repeat (n) send_pixel(pngenc_pkg::pix_t'(24'($urandom)));
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    wait (file_bytes_q.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(negedge clk) cfg_we <= 1'b0;
    if (idx == pngenc_pkg::CFG_IDX_WIDTH) reg_w = v;
    else reg_h = v;
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(pngenc_pkg::CFG_IDX_WIDTH, w[15:0]);
    write_reg(pngenc_pkg::CFG_IDX_HEIGHT, h[15:0]);
  endtask

  // receiver: random stalls, or a long counted hold-off
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    pngenc_pkg::res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (file_bytes_q.size() == 0) report($sformatf("unexpected byte %h", out_data.out_byte));
      else begin
        e = file_bytes_q.pop_front();
        if (out_data.out_byte !== e.out_byte)
          report($sformatf("out_byte %h, want %h", out_data.out_byte, e.out_byte));
        if (out_data.run_last !== e.run_last)
          report($sformatf("run_last %b, want %b", out_data.run_last, e.run_last));
        if (out_data.file_last !== e.file_last)
          report($sformatf("file_last %b, want %b", out_data.file_last, e.file_last));
      end
    end
  end

  // one-pixel files, extreme bytes, zero dimensions, a write in mid image
  task automatic test_directed();
    send_pixel('{8'h00, 8'h00, 8'h00});
    send_pixel('{8'hFF, 8'hFF, 8'hFF});
    drain();
    set_size(0, 0);
    send_pixel('{8'hA5, 8'h5A, 8'hFF});
    drain();
    set_size(2, 2);
    send_pixel('{8'h00, 8'hFF, 8'h55});
    send_pixel('{8'hAA, 8'h01, 8'h80});
    send_pixel('{8'hFE, 8'h7F, 8'h00});
    send_pixel('{8'h55, 8'hAA, 8'hFF});
    drain();
    set_size(3, 2);
    send_rand(2);
    drain();
    // takes effect with the next image only
    set_size(5, 1);
    send_rand(4);
    send_rand(5);
    drain();
  endtask

  task automatic test_random_images(input int ip, input int sp, input int budget);
    int w, h;
    idle_pct = ip;
    stall_pct = sp;
    while (budget > 0) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
      h = $urandom_range(5, 1);
      drain();
      set_size(w, h);
      send_rand(w * h);
      budget -= w * h;
    end
    drain();
  endtask

  // output held off while pixels keep coming, then a full pause
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    set_size(6, 4);
    hold_left = 600;
    send_rand(24);
    drain();
  endtask

  // tall image whose data needs several stored blocks, left unfinished
  task automatic test_tall_image();
    idle_pct = 0;
    stall_pct = 0;
    set_size(1, 65535);
    send_rand(6);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    reg_w = 1; reg_h = 1;
    in_file = 0;
    col = 0; row = 0; blk_left = 0; raw_left = 0;
    ad_lo = 1; ad_hi = 0;
    idat_crc = 32'hFFFFFFFF;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_directed();
    test_random_images(0, 0, 100);
    test_random_images(62, 0, 100);
    test_random_images(0, 62, 100);
    test_random_images(21, 21, 100);
    test_backpressure();
    test_tall_image();
    @(negedge clk) in_valid <= 1'b0;
    wait (file_bytes_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("tb_png_rgb_stored_deflate_encoder: PASS");
    else $display("tb_png_rgb_stored_deflate_encoder: FAIL");
    $finish;
  end

endmodule
